### design/ledseq_pkg.sv
`timescale 1ns / 1ps

package ledseq_pkg;

    localparam int PATTERN_BITS = 8;
    localparam int TICK_W       = 21;
    localparam int BITPOS_W     = 5;
    localparam int STATUS_W     = 4;
    localparam int PHASE_W      = 3;
    localparam int NUM_CODES    = 10;
    localparam int TABLE_BITS   = 8;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    typedef logic [TICK_W-1:0]     tick_t;
    typedef logic [BITPOS_W-1:0]   bitpos_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [TABLE_BITS-1:0] pattern_t;

    localparam tick_t   TICK_MAX   = {TICK_W{1'b1}};
    localparam bitpos_t START_MARK = {BITPOS_W{1'b1}};

    localparam tick_t ON_TICKS_RST    = 21'd100000;
    localparam tick_t BIT_TICKS_RST   = 21'd200000;
    localparam tick_t CYCLE_TICKS_RST = 21'd1200000;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ON_TICKS    = 2'd0;
    localparam logic [1:0] REG_BIT_TICKS   = 2'd1;
    localparam logic [1:0] REG_CYCLE_TICKS = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // blink code for each status, codes without an entry stay dark
    function automatic pattern_t code_pattern(input status_t code);
        pattern_t pat;
        begin
            case (code)
                4'd0:    pat = 8'b0011_1000;
                4'd1:    pat = 8'b0111_1000;
                4'd2:    pat = 8'b0000_0010;
                4'd3:    pat = 8'b0000_0110;
                4'd4:    pat = 8'b0000_0000;
                4'd5:    pat = 8'b0000_0001;
                4'd6:    pat = 8'b0000_0011;
                4'd7:    pat = 8'b0000_0111;
                4'd8:    pat = 8'b0000_0101;
                4'd9:    pat = 8'b0000_1101;
                default: pat = '0;
            endcase
            return pat;
        end
    endfunction

endpackage

### design/ledseq_if.sv
`timescale 1ns / 1ps

interface ledseq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    ledseq_pkg::status_t       status_code;

    modport source (output valid, output command, output status_code, input ready);
    modport sink   (input valid, input command, input status_code, output ready);
endinterface

interface ledseq_out_if;
    logic valid;
    logic ready;
    logic led_on;

    modport source (output valid, output led_on, input ready);
    modport sink   (input valid, input led_on, output ready);
endinterface

### design/status_led_blink_pattern_sequencer_unit.sv
`timescale 1ns / 1ps

// channel   dir   handshake      payload
// in_ch     in    valid/ready    command (1), status_code (4)
// out_ch    out   valid/ready    led_on (1)
// apb       in    psel/penable   paddr (4), pwdata/prdata (32), pready tied high
//
// one word in, one word out; a word is taken every cycle while the result
// register is empty or being drained, so throughput is one word per cycle;
// the result is held in the single state/result register stage and is out in the cycle after its word.
// rst_n clears the sequencer state to init and the timing registers to defaults.
// a stall on out_ch holds the result and blocks in_ch until it is taken.

module status_led_blink_pattern_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    ledseq_in_if.sink                         in_ch,
    ledseq_out_if.source                      out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ledseq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ledseq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ledseq_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);

    localparam logic [ledseq_pkg::PHASE_W-1:0] PH_INIT       = 3'd0;
    localparam logic [ledseq_pkg::PHASE_W-1:0] PH_UPDATE     = 3'd1;
    localparam logic [ledseq_pkg::PHASE_W-1:0] PH_ON_WAIT    = 3'd2;
    localparam logic [ledseq_pkg::PHASE_W-1:0] PH_OFF_WAIT   = 3'd3;
    localparam logic [ledseq_pkg::PHASE_W-1:0] PH_CYCLE_WAIT = 3'd4;

    ledseq_pkg::tick_t on_ticks_reg;
    ledseq_pkg::tick_t bit_ticks_reg;
    ledseq_pkg::tick_t cycle_ticks_reg;

    logic [ledseq_pkg::PHASE_W-1:0] phase_reg, phase_next;
    ledseq_pkg::tick_t              elapsed_reg, elapsed_next;
    ledseq_pkg::bitpos_t            bitpos_reg, bitpos_next;
    ledseq_pkg::status_t            shown_reg, shown_next;
    ledseq_pkg::status_t            pending_reg, pending_next;
    logic                           led_reg, led_next;
    logic                           out_valid_reg;
    logic                           out_led_reg;

    logic                           in_accept;
    logic                           cfg_write;
    logic [1:0]                     cfg_idx;
    ledseq_pkg::tick_t              elapsed_inc;
    ledseq_pkg::pattern_t           pattern;
    logic                           slot_level;
    ledseq_pkg::bitpos_t            bitpos_inc;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= ledseq_pkg::ON_TICKS_RST;
            bit_ticks_reg   <= ledseq_pkg::BIT_TICKS_RST;
            cycle_ticks_reg <= ledseq_pkg::CYCLE_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                ledseq_pkg::REG_ON_TICKS:    on_ticks_reg    <= pwdata[ledseq_pkg::TICK_W-1:0];
                ledseq_pkg::REG_BIT_TICKS:   bit_ticks_reg   <= pwdata[ledseq_pkg::TICK_W-1:0];
                ledseq_pkg::REG_CYCLE_TICKS: cycle_ticks_reg <= pwdata[ledseq_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            ledseq_pkg::REG_ON_TICKS:
                prdata = {{(ledseq_pkg::APB_DATA_W-ledseq_pkg::TICK_W){1'b0}}, on_ticks_reg};
            ledseq_pkg::REG_BIT_TICKS:
                prdata = {{(ledseq_pkg::APB_DATA_W-ledseq_pkg::TICK_W){1'b0}}, bit_ticks_reg};
            ledseq_pkg::REG_CYCLE_TICKS:
                prdata = {{(ledseq_pkg::APB_DATA_W-ledseq_pkg::TICK_W){1'b0}}, cycle_ticks_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign in_ch.ready   = !out_valid_reg || out_ch.ready;
    assign in_accept     = in_ch.valid && in_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.led_on = out_led_reg;

    // ---------------- sequencer ----------------
    assign elapsed_inc = (elapsed_reg == ledseq_pkg::TICK_MAX) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;
    assign pattern     = ledseq_pkg::code_pattern(shown_reg);
    assign bitpos_inc  = bitpos_reg + 1'b1;

    // start blink for any position past the pattern, table bits beyond 8 dark
    always_comb
    begin
        if (bitpos_reg >= ledseq_pkg::BITPOS_W'(ledseq_pkg::PATTERN_BITS))
            slot_level = 1'b1;
        else if (bitpos_reg < ledseq_pkg::BITPOS_W'(ledseq_pkg::TABLE_BITS))
            slot_level = pattern[bitpos_reg[$clog2(ledseq_pkg::TABLE_BITS)-1:0]];
        else
            slot_level = 1'b0;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        bitpos_next  = bitpos_reg;
        shown_next   = shown_reg;
        pending_next = pending_reg;
        led_next     = led_reg;
        if (in_ch.command == ledseq_pkg::CMD_SET)
        begin
            pending_next = in_ch.status_code;
        end
        else
        begin
            elapsed_next = elapsed_inc;
            unique case (phase_reg)
                PH_INIT:
                    phase_next = PH_UPDATE;
                PH_UPDATE:
                begin
                    if (slot_level)
                    begin
                        led_next   = 1'b1;
                        phase_next = PH_ON_WAIT;
                    end
                    else
                        phase_next = PH_OFF_WAIT;
                    elapsed_next = '0;
                end
                PH_ON_WAIT:
                    if (elapsed_inc >= on_ticks_reg)
                    begin
                        led_next   = 1'b0;
                        phase_next = PH_OFF_WAIT;
                    end
                PH_OFF_WAIT:
                    if (elapsed_inc >= bit_ticks_reg)
                    begin
                        if (bitpos_inc >= ledseq_pkg::BITPOS_W'(ledseq_pkg::PATTERN_BITS))
                        begin
                            bitpos_next = ledseq_pkg::START_MARK;
                            phase_next  = PH_CYCLE_WAIT;
                        end
                        else
                        begin
                            bitpos_next = bitpos_inc;
                            phase_next  = PH_INIT;
                        end
                    end
                PH_CYCLE_WAIT:
                    if (elapsed_inc >= cycle_ticks_reg)
                    begin
                        shown_next = pending_reg;
                        phase_next = PH_INIT;
                    end
                default:
                    phase_next = PH_INIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            elapsed_reg   <= '0;
            bitpos_reg    <= '0;
            shown_reg     <= '0;
            pending_reg   <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                bitpos_reg    <= bitpos_next;
                shown_reg     <= shown_next;
                pending_reg   <= pending_next;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result word holds the level after the item
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_led_reg <= led_next;
    end

    // ---------------- checks ----------------
    a_led_only_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> (phase_reg == PH_ON_WAIT))
        else $error("led lit outside on wait");

    a_bitpos_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (bitpos_reg < ledseq_pkg::BITPOS_W'(ledseq_pkg::PATTERN_BITS))
        || (bitpos_reg == ledseq_pkg::START_MARK))
        else $error("bit position out of range");

    a_set_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.command == ledseq_pkg::CMD_SET)
        |=> ($stable(phase_reg) && $stable(elapsed_reg) && $stable(led_reg)))
        else $error("set command advanced the sequencer");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (out_valid_reg && out_led_reg == led_reg))
        else $error("accepted word has no matching result");

endmodule

### dv/tb_status_led_blink_pattern_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_status_led_blink_pattern_sequencer_unit;
    import ledseq_pkg::*;

    typedef enum logic [2:0] {
        SEQ_INIT,
        SEQ_UPDATE,
        SEQ_ON_WAIT,
        SEQ_OFF_WAIT,
        SEQ_CYCLE_WAIT
    } seq_phase_e;

    typedef struct packed {
        logic    command;
        status_t status_code;
    } in_word_t;

    localparam pattern_t BLINK_CODES [NUM_CODES] = '{
        8'h38, 8'h78, 8'h02, 8'h06, 8'h00, 8'h01, 8'h03, 8'h07, 8'h05, 8'h0D
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ledseq_in_if  in_ch ();
    ledseq_out_if out_ch ();

    status_led_blink_pattern_sequencer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // sequencer state as predicted
    seq_phase_e phase_m;
    tick_t      elapsed_m;
    bitpos_t    bitpos_m;
    status_t    shown_m;
    status_t    pending_m;
    logic       led_m;
    tick_t      on_len;
    tick_t      slot_len;
    tick_t      repeat_len;

    in_word_t   words_to_send[$];
    logic       led_levels_due[$];
    in_word_t   next_word;
    logic       due_led;
    logic       in_taken;
    logic       quiet;
    int         mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_status_led_blink_pattern_sequencer_unit: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $time);
    endtask

    function automatic logic slot_lit(input bitpos_t pos, input status_t code);
        pattern_t pat;
        pat = (code < NUM_CODES) ? BLINK_CODES[code] : '0;
        if (pos >= PATTERN_BITS)
            return 1'b1;
        if (pos >= TABLE_BITS)
            return 1'b0;
        return pat[pos[$clog2(TABLE_BITS)-1:0]];
    endfunction

    task automatic blink_tick();
        if (elapsed_m != TICK_MAX)
            elapsed_m = elapsed_m + 1'b1;
        case (phase_m)
            SEQ_INIT:
                phase_m = SEQ_UPDATE;
            SEQ_UPDATE:
            begin
                if (slot_lit(bitpos_m, shown_m))
                begin
                    led_m   = 1'b1;
                    phase_m = SEQ_ON_WAIT;
                end
                else
                    phase_m = SEQ_OFF_WAIT;
                elapsed_m = '0;
            end
            SEQ_ON_WAIT:
                if (elapsed_m >= on_len)
                begin
                    led_m   = 1'b0;
                    phase_m = SEQ_OFF_WAIT;
                end
            SEQ_OFF_WAIT:
                if (elapsed_m >= slot_len)
                begin
                    bitpos_m = bitpos_m + 1'b1;
                    if (bitpos_m >= PATTERN_BITS)
                    begin
                        // past the last bit: start blink leads the next pattern
                        bitpos_m = START_MARK;
                        phase_m  = SEQ_CYCLE_WAIT;
                    end
                    else
                        phase_m = SEQ_INIT;
                end
            SEQ_CYCLE_WAIT:
                if (elapsed_m >= repeat_len)
                begin
                    shown_m = pending_m;
                    phase_m = SEQ_INIT;
                end
            default:
                phase_m = SEQ_INIT;
        endcase
    endtask

    // monitor: predict on each accepted input word, check each output word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == CMD_SET)
                    pending_m = in_ch.status_code;
                else
                    blink_tick();
                led_levels_due.push_back(led_m);
                in_taken <= 1'b1;
            end
            else
                in_taken <= 1'b0;
            if (out_ch.valid && out_ch.ready)
            begin
                if (led_levels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word led_on=%0b at %0t",
                                 out_ch.led_on, $time);
                end
                else
                begin
                    due_led = led_levels_due.pop_front();
                    if (out_ch.led_on !== due_led)
                        report_mismatch("led_on", due_led, out_ch.led_on);
                end
            end
        end
    end

    // driver: input words from the queue, random stalls on the output side
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (words_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    next_word = words_to_send.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.command     <= next_word.command;
                    in_ch.status_code <= next_word.status_code;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic push_tick(input int n);
        repeat (n)
            words_to_send.push_back('{command: CMD_TICK, status_code: status_t'($urandom)});
    endtask

    task automatic push_set(input status_t code);
        words_to_send.push_back('{command: CMD_SET, status_code: code});
    endtask

    task automatic add_random(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 12)
                push_set(status_t'($urandom_range(0, 15)));
            else
                push_tick(1);
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_ch.valid || led_levels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic wr, input tick_t val,
                              output logic [APB_DATA_W-1:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timing(input tick_t on_v, input tick_t bit_v, input tick_t cyc_v);
        logic [APB_DATA_W-1:0] rd;
        apb_access(REG_ON_TICKS, 1'b1, on_v, rd);
        apb_access(REG_BIT_TICKS, 1'b1, bit_v, rd);
        apb_access(REG_CYCLE_TICKS, 1'b1, cyc_v, rd);
        on_len     = on_v;
        slot_len   = bit_v;
        repeat_len = cyc_v;
        apb_access(REG_ON_TICKS, 1'b0, '0, rd);
        if (rd[TICK_W-1:0] !== on_v)
            report_mismatch("on_ticks readback", on_v, rd[TICK_W-1:0]);
        apb_access(REG_BIT_TICKS, 1'b0, '0, rd);
        if (rd[TICK_W-1:0] !== bit_v)
            report_mismatch("bit_ticks readback", bit_v, rd[TICK_W-1:0]);
        apb_access(REG_CYCLE_TICKS, 1'b0, '0, rd);
        if (rd[TICK_W-1:0] !== cyc_v)
            report_mismatch("cycle_ticks readback", cyc_v, rd[TICK_W-1:0]);
    endtask

    // two halves, the sender holding off until every word is back in between
    task automatic run_phase(input tick_t on_v, input tick_t bit_v, input tick_t cyc_v,
                             input int n);
        set_timing(on_v, bit_v, cyc_v);
        add_random(n / 2);
        wait_drained();
        add_random(n - n / 2);
        wait_drained();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_TICK;
        in_ch.status_code = '0;
        out_ch.ready      = 1'b0;
        in_taken          = 1'b0;
        quiet             = 1'b0;
        mismatches        = 0;
        phase_m           = SEQ_INIT;
        elapsed_m         = '0;
        bitpos_m          = '0;
        shown_m           = '0;
        pending_m         = '0;
        led_m             = 1'b0;
        on_len            = ON_TICKS_RST;
        slot_len          = BIT_TICKS_RST;
        repeat_len        = CYCLE_TICKS_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset timing: first pattern has no start blink, status 0 opens dark
        push_tick(4);
        wait_drained();

        // short slots so whole patterns and status changes show up
        set_timing(21'd1, 21'd2, 21'd3);
        push_set(4'd9);
        push_tick(6);
        push_set(4'd15);
        push_set(4'd10);
        push_tick(8);
        push_set(4'd0);
        push_tick(4);
        wait_drained();

        run_phase(21'd1, 21'd1, 21'd1, 250);
        run_phase(21'd0, 21'd0, 21'd0, 150);
        quiet = 1'b1;
        run_phase(21'd3, 21'd5, 21'd30, 250);
        quiet = 1'b0;
        // lit time longer than the slot
        run_phase(21'd6, 21'd4, 21'd20, 200);
        repeat (2)
            run_phase(tick_t'($urandom_range(1, 8)), tick_t'($urandom_range(1, 12)),
                      tick_t'($urandom_range(1, 80)), 310);
        // repeat wait that does not end within the run
        run_phase(21'd2, 21'd4, TICK_MAX, 60);
        run_phase(TICK_MAX, TICK_MAX, TICK_MAX, 40);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_status_led_blink_pattern_sequencer_unit: done, clean");
        else
            $display("tb_status_led_blink_pattern_sequencer_unit: done, errors");
        $finish;
    end

endmodule

### files.f
design/ledseq_pkg.sv
design/ledseq_if.sv
design/status_led_blink_pattern_sequencer_unit.sv
dv/tb_status_led_blink_pattern_sequencer_unit.sv
